@@ hw/rtl/lcdseq_pkg.sv @@
package lcdseq_pkg;

  // command codes of the request word
  typedef enum logic [3:0] {
    CMD_WRITE    = 4'd0,
    CMD_SET_POS  = 4'd1,
    CMD_UP       = 4'd2,
    CMD_DOWN     = 4'd3,
    CMD_LEFT     = 4'd4,
    CMD_RIGHT    = 4'd5,
    CMD_CLEAR    = 4'd6,
    CMD_FLAGS    = 4'd7,
    CMD_WRITE_AT = 4'd8,
    CMD_INIT     = 4'd9
  } cmd_e;

  // lcd instruction bytes
  localparam logic [7:0] LCD_CLEAR      = 8'h01;
  localparam logic [7:0] LCD_SET_ADDR   = 8'h80;
  localparam logic [7:0] LCD_FUNC_SET   = 8'h28;
  localparam logic [7:0] LCD_DISP_ALL   = 8'h0F;
  localparam logic [7:0] LCD_ENTRY_MODE = 8'h06;
  localparam logic [4:0] LCD_DISP_CTRL  = 5'b00001;
  // wake-up nibbles 3,3,3,2 sent as two byte slots
  localparam logic [7:0] LCD_WAKE_A     = 8'h33;
  localparam logic [7:0] LCD_WAKE_B     = 8'h32;

  // rs values
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // cursor limits
  localparam logic [6:0] POS_END  = 7'd64;
  localparam logic [6:0] ROW_STEP = 7'd16;
  localparam logic [6:0] TOP_LAST = 7'd15;
  localparam logic [6:0] BOT_ROW  = 7'd48;
  localparam logic [2:0] FLAGS_RESET = 3'b111;
  localparam logic [2:0] BLINK_OFF   = 3'b110;

  // most bytes any command expands into
  localparam int JOB_SLOTS = 7;
  localparam int SLOT_W    = $clog2(JOB_SLOTS + 1);
  localparam int NIB_W     = $clog2(2 * JOB_SLOTS);

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] cmd;
    logic [7:0] char_code;
    logic [6:0] target_pos;
    logic [2:0] flag_bits;
  } req_word_t;

  typedef struct packed {
    logic       reg_select;
    logic [3:0] nibble;
    logic       last;
    logic [6:0] cursor_now;
  } xfer_word_t;

  // one command, expanded into a run of bytes
  typedef struct packed {
    logic [SLOT_W-1:0]              byte_cnt;
    logic [JOB_SLOTS-1:0]           rs;
    logic [JOB_SLOTS-1:0][7:0]      data;
    logic [6:0]                     cursor_now;
  } job_t;

endpackage

@@ hw/rtl/char_lcd_cursor_nibble_sequencer.sv @@
// a taken request goes to the job queue, then its words to the output register
// throughput: one nibble word per cycle from the single output register,
//   unless xfer_ready stalls it; two words per byte (write char 4 or 6, init 14)
// requests are taken every cycle while the two-entry job queue has room
// reset: cursor 0, display flags 3'b111, job queue and output register empty
module char_lcd_cursor_nibble_sequencer import lcdseq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_word_t  req,
  output logic       xfer_valid,
  input  logic       xfer_ready,
  output xfer_word_t xfer
);

  logic q_full;
  logic q_push;
  logic q_pop;
  logic q_empty;
  job_t q_wjob;
  job_t q_head;

  // decode and cursor tracking
  lcdseq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_wjob)
  );

  // job queue
  lcdseq_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wjob),
    .full  (q_full),
    .pop   (q_pop),
    .head  (q_head),
    .empty (q_empty)
  );

  // nibble serializer
  lcdseq_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .xfer_valid (xfer_valid),
    .xfer_ready (xfer_ready),
    .xfer       (xfer)
  );

endmodule

@@ hw/rtl/lcdseq_front.sv @@
module lcdseq_front import lcdseq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_word_t req,
  input  logic      q_full,
  output logic      q_push,
  output job_t      q_job
);

  logic [6:0] cursor_pos;
  logic [2:0] display_flags;
  logic [6:0] cursor_pos_next;
  logic [2:0] display_flags_next;
  logic       accept;
  job_t       job;

  // append one byte to the job
  function automatic void push_byte(inout job_t j, input logic rs, input logic [7:0] b);
    j.data[j.byte_cnt] = b;
    j.rs[j.byte_cnt]   = rs;
    j.byte_cnt         = j.byte_cnt + SLOT_W'(1);
  endfunction

  // address set for a position, or clear and home when off screen
  function automatic void push_goto(inout job_t j, input logic [6:0] p);
    if (!p[6]) begin
      push_byte(j, RS_INSTR, {1'b1, p[4], 1'b0, p[5], p[3:0]});
    end else begin
      push_byte(j, RS_INSTR, LCD_CLEAR);
      push_byte(j, RS_INSTR, LCD_SET_ADDR);
    end
  endfunction

  // where the cursor lands after a goto
  function automatic logic [6:0] land(input logic [6:0] p);
    return p[6] ? 7'd0 : p;
  endfunction

  // decode the command into a byte run and the next cursor state
  always_comb begin
    job                = '0;
    cursor_pos_next    = cursor_pos;
    display_flags_next = display_flags;
    unique case (req.cmd)
      CMD_WRITE: begin
        push_goto(job, cursor_pos);
        push_byte(job, RS_DATA, req.char_code);
        cursor_pos_next = land(cursor_pos) + 7'd1;
      end
      CMD_SET_POS: begin
        push_goto(job, req.target_pos);
        cursor_pos_next = land(req.target_pos);
      end
      CMD_UP: begin
        if (cursor_pos > TOP_LAST) begin
          push_goto(job, cursor_pos - ROW_STEP);
          cursor_pos_next = cursor_pos - ROW_STEP;
        end
      end
      CMD_DOWN: begin
        if (cursor_pos < BOT_ROW) begin
          push_goto(job, cursor_pos + ROW_STEP);
          cursor_pos_next = cursor_pos + ROW_STEP;
        end
      end
      CMD_LEFT: begin
        if (cursor_pos[3:0] != 4'd0) begin
          push_goto(job, cursor_pos - 7'd1);
          cursor_pos_next = cursor_pos - 7'd1;
        end
      end
      CMD_RIGHT: begin
        if (cursor_pos[3:0] != 4'hF) begin
          push_goto(job, cursor_pos + 7'd1);
          cursor_pos_next = land(cursor_pos + 7'd1);
        end
      end
      CMD_CLEAR: begin
        push_byte(job, RS_INSTR, LCD_CLEAR);
        cursor_pos_next = 7'd0;
      end
      CMD_FLAGS: begin
        push_byte(job, RS_INSTR, {LCD_DISP_CTRL, req.flag_bits});
        display_flags_next = req.flag_bits;
      end
      CMD_WRITE_AT: begin
        push_goto(job, req.target_pos);
        push_goto(job, land(req.target_pos));
        push_byte(job, RS_DATA, req.char_code);
        push_goto(job, cursor_pos);
        cursor_pos_next = land(cursor_pos);
      end
      CMD_INIT: begin
        push_byte(job, RS_INSTR, LCD_WAKE_A);
        push_byte(job, RS_INSTR, LCD_WAKE_B);
        push_byte(job, RS_INSTR, LCD_FUNC_SET);
        push_byte(job, RS_INSTR, LCD_DISP_ALL);
        push_byte(job, RS_INSTR, LCD_CLEAR);
        push_byte(job, RS_INSTR, LCD_ENTRY_MODE);
        push_byte(job, RS_INSTR, {LCD_DISP_CTRL, display_flags & BLINK_OFF});
        display_flags_next = display_flags & BLINK_OFF;
        cursor_pos_next    = 7'd0;
      end
      default: begin
        job = '0;
      end
    endcase
    job.cursor_now = cursor_pos_next;
  end

  assign req_ready = !q_full;
  assign accept    = req_valid && req_ready;
  // commands that move nothing leave no job behind
  assign q_push    = accept && (job.byte_cnt != '0);
  assign q_job     = job;

  // cursor and flag state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_pos    <= 7'd0;
      display_flags <= FLAGS_RESET;
    end else if (accept) begin
      cursor_pos    <= cursor_pos_next;
      display_flags <= display_flags_next;
    end
  end

endmodule

@@ hw/rtl/lcdseq_queue.sv @@
module lcdseq_queue import lcdseq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output job_t head,
  output logic empty
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // pointer wrap at the queue depth
  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  // occupancy and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/lcdseq_back.sv @@
module lcdseq_back import lcdseq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  job_t       head,
  input  logic       empty,
  output logic       pop,
  output logic       xfer_valid,
  input  logic       xfer_ready,
  output xfer_word_t xfer
);

  logic [NIB_W-1:0]  idx;
  logic              load;
  logic              nib_last;
  logic [2:0]        slot;
  logic [7:0]        cur_byte;
  xfer_word_t        word_next;

  function automatic logic [NIB_W-2:0] slot_last(input logic [SLOT_W-1:0] cnt);
    return (NIB_W - 1)'(cnt - SLOT_W'(1));
  endfunction

  // pick the current nibble out of the head job
  always_comb begin
    slot      = idx[NIB_W-1:1];
    cur_byte  = head.data[slot];
    nib_last  = (idx == {slot_last(head.byte_cnt), 1'b1});
    word_next.reg_select = head.rs[slot];
    word_next.nibble     = idx[0] ? cur_byte[3:0] : cur_byte[7:4];
    word_next.last       = nib_last;
    word_next.cursor_now = head.cursor_now;
  end

  assign load = !empty && (!xfer_valid || xfer_ready);
  assign pop  = load && nib_last;

  // nibble counter within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= nib_last ? '0 : idx + NIB_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      xfer_valid <= 1'b0;
    end else if (load) begin
      xfer_valid <= 1'b1;
    end else if (xfer_ready) begin
      xfer_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      xfer <= word_next;
    end
  end

endmodule

@@ hw/rtl/lcdseq_checker.sv @@
module lcdseq_checker import lcdseq_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       xfer_valid,
  input logic       xfer_ready,
  input xfer_word_t xfer
);

  // reset leaves the block empty and open for requests
  a_reset_empty: assert property (@(posedge clk)
    rst |=> req_ready && !xfer_valid)
    else $error("block not empty after reset");

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    xfer_valid && !xfer_ready |=> xfer_valid && $stable(xfer))
    else $error("stalled word changed");

  // every word of one command carries the same cursor
  a_cursor_same: assert property (@(posedge clk) disable iff (rst)
    (xfer_valid && xfer_ready && !xfer.last) ##1 xfer_valid |->
      xfer.cursor_now == $past(xfer.cursor_now))
    else $error("cursor changed within a command");

  // cursor stays on or just past the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    xfer_valid |-> xfer.cursor_now <= POS_END)
    else $error("cursor out of range");

endmodule

bind char_lcd_cursor_nibble_sequencer lcdseq_checker u_chk (.*);

@@ tb/lcd_xfer_checker.sv @@
module lcd_xfer_checker import lcdseq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_word_t  req,
  input  logic       xfer_valid,
  input  logic       xfer_ready,
  input  xfer_word_t xfer,
  output int         error_count,
  output int         words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // instruction bytes and bus values as the panel expects them
  localparam logic [7:0] BYTE_CLEAR    = 8'h01;
  localparam logic [7:0] BYTE_SET_ADDR = 8'h80;
  localparam logic [7:0] BYTE_FUNC_SET = 8'h28;
  localparam logic [7:0] BYTE_DISP_ALL = 8'h0F;
  localparam logic [7:0] BYTE_ENTRY    = 8'h06;
  localparam logic [7:0] BYTE_DISP_CTL = 8'h08;
  localparam logic [7:0] ODD_ROW_BASE  = 8'h40;
  localparam logic [7:0] LOW_ROW_BASE  = 8'h10;
  localparam logic [3:0] WAKE_NIB      = 4'h3;
  localparam logic [3:0] WAKE_4BIT_NIB = 4'h2;
  localparam logic [6:0] CURSOR_END    = 7'd64;
  localparam logic [6:0] ROW_LEN       = 7'd16;
  localparam logic [2:0] FLAGS_ALL_ON  = 3'b111;
  localparam logic [2:0] NO_BLINK_MASK = 3'b110;

  logic [6:0] cursor = '0;
  logic [2:0] flags  = FLAGS_ALL_ON;
  int         errors = 0;
  xfer_word_t expected_xfers[$];
  xfer_word_t cmd_words[$];
  xfer_word_t oldest;

  function automatic void put_nibble(logic rs, logic [3:0] nib);
    xfer_word_t w;
    w            = '0;
    w.reg_select = rs;
    w.nibble     = nib;
    cmd_words.push_back(w);
  endfunction

  function automatic void put_byte(logic rs, logic [7:0] b);
    put_nibble(rs, b[7:4]);
    put_nibble(rs, b[3:0]);
  endfunction

  // address the panel at a linear position, or clear and home past the end
  function automatic void move_to(logic [6:0] p);
    logic [7:0] addr;
    if (p < CURSOR_END) begin
      addr = {4'h0, p[3:0]};
      if (p[4]) addr |= ODD_ROW_BASE;
      if (p[5]) addr |= LOW_ROW_BASE;
      put_byte(RS_INSTR, BYTE_SET_ADDR | addr);
      cursor = p;
    end else begin
      put_byte(RS_INSTR, BYTE_CLEAR);
      put_byte(RS_INSTR, BYTE_SET_ADDR);
      cursor = '0;
    end
  endfunction

  function automatic void write_char(logic [7:0] c);
    move_to(cursor);
    put_byte(RS_DATA, c);
    cursor = cursor + 7'd1;
  endfunction

  // expand one request into its bus words and queue them
  function automatic void expand_command(req_word_t r);
    logic [6:0] saved_pos;
    logic [6:0] next_pos;
    cmd_words.delete();
    next_pos = cursor + 7'd1;
    case (r.cmd)
      CMD_WRITE:   write_char(r.char_code);
      CMD_SET_POS: move_to(r.target_pos);
      CMD_UP:      if (cursor >= ROW_LEN) move_to(cursor - ROW_LEN);
      CMD_DOWN:    if (cursor < CURSOR_END - ROW_LEN) move_to(cursor + ROW_LEN);
      CMD_LEFT:    if (cursor[3:0] != 4'd0) move_to(cursor - 7'd1);
      CMD_RIGHT:   if (next_pos[3:0] != 4'd0) move_to(next_pos);
      CMD_CLEAR: begin
        cursor = '0;
        put_byte(RS_INSTR, BYTE_CLEAR);
      end
      CMD_FLAGS: begin
        flags = r.flag_bits;
        put_byte(RS_INSTR, BYTE_DISP_CTL | 8'(flags));
      end
      CMD_WRITE_AT: begin
        saved_pos = cursor;
        move_to(r.target_pos);
        write_char(r.char_code);
        move_to(saved_pos);
      end
      CMD_INIT: begin
        cursor = '0;
        put_nibble(RS_INSTR, WAKE_NIB);
        put_nibble(RS_INSTR, WAKE_NIB);
        put_nibble(RS_INSTR, WAKE_NIB);
        put_nibble(RS_INSTR, WAKE_4BIT_NIB);
        put_byte(RS_INSTR, BYTE_FUNC_SET);
        put_byte(RS_INSTR, BYTE_DISP_ALL);
        put_byte(RS_INSTR, BYTE_CLEAR);
        put_byte(RS_INSTR, BYTE_ENTRY);
        flags = flags & NO_BLINK_MASK;
        put_byte(RS_INSTR, BYTE_DISP_CTL | 8'(flags));
      end
      default: ;
    endcase
    foreach (cmd_words[k]) begin
      cmd_words[k].last       = (k == cmd_words.size() - 1);
      cmd_words[k].cursor_now = cursor;
      expected_xfers.push_back(cmd_words[k]);
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  // predict on accepted requests, compare accepted words against the oldest
  always @(posedge clk) begin
    if (rst) begin
      cursor = '0;
      flags  = FLAGS_ALL_ON;
      expected_xfers.delete();
    end else begin
      if (req_valid && req_ready) expand_command(req);
      if (xfer_valid && xfer_ready) begin
        if (expected_xfers.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, got rs=%0d nib=%0h last=%0d cur=%0d",
                   $time, xfer.reg_select, xfer.nibble, xfer.last, xfer.cursor_now);
        end else begin
          oldest = expected_xfers.pop_front();
          check_field("reg_select", 32'(oldest.reg_select), 32'(xfer.reg_select));
          check_field("nibble", 32'(oldest.nibble), 32'(xfer.nibble));
          check_field("last", 32'(oldest.last), 32'(xfer.last));
          check_field("cursor_now", 32'(oldest.cursor_now), 32'(xfer.cursor_now));
        end
      end
    end
    error_count   <= errors;
    words_pending <= expected_xfers.size();
  end

endmodule

@@ tb/tb_char_lcd_cursor_nibble_sequencer.sv @@
module tb_char_lcd_cursor_nibble_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import lcdseq_pkg::*;

  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         DRAIN_CYCLES = 30;
  localparam int         RANDOM_ITEMS = 185;
  localparam int         QUIET_ITEMS  = 40;
  localparam int         STALL_AT     = 60;
  localparam int         PAUSE_AT     = 110;
  localparam logic [3:0] CMD_NONE     = 4'hF;

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       req_valid  = 1'b0;
  logic       req_ready;
  req_word_t  req        = '0;
  logic       xfer_valid;
  logic       xfer_ready = 1'b0;
  xfer_word_t xfer;

  int mismatches;
  int pending;
  int stall_asked = 0;
  int stall_done  = 0;
  bit quiet       = 1'b0;
  int cycles      = 0;

  char_lcd_cursor_nibble_sequencer i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .xfer_valid (xfer_valid),
    .xfer_ready (xfer_ready),
    .xfer       (xfer)
  );

  lcd_xfer_checker i_check (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .xfer_valid    (xfer_valid),
    .xfer_ready    (xfer_ready),
    .xfer          (xfer),
    .error_count   (mismatches),
    .words_pending (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // bus side: random ready bursts, one long hold when asked
  initial begin
    @(posedge clk);
    forever begin
      if (stall_done < stall_asked) begin
        xfer_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_done++;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        xfer_ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 12)) @(posedge clk);
      end else begin
        xfer_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  function automatic req_word_t make_req(logic [3:0] cmd, logic [7:0] ch,
                                         logic [6:0] pos, logic [2:0] fl);
    req_word_t w;
    w.cmd        = cmd;
    w.char_code  = ch;
    w.target_pos = pos;
    w.flag_bits  = fl;
    return w;
  endfunction

  // mostly in-range positions, with the last row's end and clear-and-home values mixed in
  function automatic req_word_t random_request();
    req_word_t w;
    int        pick;
    int        pos_kind;
    w.char_code = 8'($urandom_range(0, 255));
    w.flag_bits = 3'($urandom_range(0, 7));
    pos_kind    = $urandom_range(0, 7);
    if (pos_kind == 0)      w.target_pos = 7'($urandom_range(64, 127));
    else if (pos_kind == 1) w.target_pos = 7'($urandom_range(60, 63));
    else                    w.target_pos = 7'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 30)      w.cmd = CMD_WRITE;
    else if (pick < 40) w.cmd = CMD_SET_POS;
    else if (pick < 46) w.cmd = CMD_UP;
    else if (pick < 52) w.cmd = CMD_DOWN;
    else if (pick < 58) w.cmd = CMD_LEFT;
    else if (pick < 64) w.cmd = CMD_RIGHT;
    else if (pick < 69) w.cmd = CMD_CLEAR;
    else if (pick < 76) w.cmd = CMD_FLAGS;
    else if (pick < 88) w.cmd = CMD_WRITE_AT;
    else if (pick < 92) w.cmd = CMD_INIT;
    else                w.cmd = 4'($urandom_range(int'(CMD_INIT) + 1, int'(CMD_NONE)));
    return w;
  endfunction

  // offer one word and hold it until taken
  task automatic send_req(req_word_t w);
    req       <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic maybe_gap();
    if ($urandom_range(0, 2) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    req_word_t directed[$];
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // power-up, writes at both ends of the byte range, moves at row edges
    directed.push_back(make_req(CMD_INIT, 8'h00, 7'd0, 3'd7));
    directed.push_back(make_req(CMD_WRITE, 8'h00, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_WRITE, 8'hFF, 7'd127, 3'd7));
    directed.push_back(make_req(CMD_SET_POS, 8'h00, 7'd15, 3'd0));
    directed.push_back(make_req(CMD_RIGHT, 8'h00, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_LEFT, 8'h00, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_UP, 8'h00, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_DOWN, 8'h00, 7'd0, 3'd0));
    // cursor run past the last cell, then moves from there
    directed.push_back(make_req(CMD_SET_POS, 8'h00, 7'd63, 3'd0));
    directed.push_back(make_req(CMD_WRITE, 8'h41, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_LEFT, 8'h00, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_RIGHT, 8'h00, 7'd0, 3'd0));
    // write with the cursor past the end clears and homes first
    directed.push_back(make_req(CMD_SET_POS, 8'h00, 7'd63, 3'd0));
    directed.push_back(make_req(CMD_WRITE, 8'h42, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_WRITE, 8'hC3, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_SET_POS, 8'h00, 7'd127, 3'd0));
    directed.push_back(make_req(CMD_SET_POS, 8'h00, 7'd48, 3'd0));
    directed.push_back(make_req(CMD_DOWN, 8'h00, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_UP, 8'h00, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_FLAGS, 8'h00, 7'd0, 3'd0));
    // write-at from an out-of-range spot with the old cursor past the end
    directed.push_back(make_req(CMD_SET_POS, 8'h00, 7'd63, 3'd0));
    directed.push_back(make_req(CMD_WRITE, 8'h5A, 7'd0, 3'd0));
    directed.push_back(make_req(CMD_WRITE_AT, 8'h80, 7'd127, 3'd0));
    directed.push_back(make_req(CMD_NONE, 8'hFF, 7'd127, 3'd7));
    directed.push_back(make_req(CMD_CLEAR, 8'h00, 7'd0, 3'd0));

    foreach (directed[i]) begin
      send_req(directed[i]);
      maybe_gap();
    end

    // random commands: one long bus hold, one full pause, quiet tail
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == STALL_AT) stall_asked++;
      if (i == PAUSE_AT) drain_results();
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      send_req(random_request());
      if (!quiet) maybe_gap();
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/lcdseq_pkg.sv
hw/rtl/lcdseq_front.sv
hw/rtl/lcdseq_queue.sv
hw/rtl/lcdseq_back.sv
hw/rtl/char_lcd_cursor_nibble_sequencer.sv
hw/rtl/lcdseq_checker.sv
tb/lcd_xfer_checker.sv
tb/tb_char_lcd_cursor_nibble_sequencer.sv
